@@ src/stfo_pkg.sv @@
// Shared types and codes for the subscription table fan-out block.
`timescale 1ns / 1ps

package stfo_pkg;

  // Most notify results reported for one input item.
  localparam int unsigned MaxResults = 16;
  localparam int unsigned EmitCntW   = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    FUNC_SUBSCRIBE   = 2'd0,
    FUNC_UNSUBSCRIBE = 2'd1,
    FUNC_NOTIFY      = 2'd2,
    FUNC_CLEAR       = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_MAX_SUBS   = 2'd0,
    REG_SAFE_MODE  = 2'd1,
    REG_GROUP_WC   = 2'd2,
    REG_ID_WC      = 2'd3
  } reg_e;

  typedef struct packed {
    logic [7:0]  group;
    logic [7:0]  id;
    logic [31:0] ip;
    logic [15:0] port;
  } entry_t;

  // Broadcast to every cell of the table.
  typedef struct packed {
    entry_t     key;
    logic [7:0] group_wc;
    logic [7:0] id_wc;
  } cell_ctrl_t;

endpackage

@@ src/stfo_cell.sv @@
// One table slot: holds an entry, loads the key or shifts from its upper neighbor, compares against the key.
`timescale 1ns / 1ps

module stfo_cell (
  input  logic                clk_i,
  input  stfo_pkg::cell_ctrl_t ctrl_i,
  input  logic                shift_en_i,
  input  logic                load_en_i,
  input  stfo_pkg::entry_t    next_entry_i,
  output stfo_pkg::entry_t    entry_o,
  output logic                key_eq_o,
  output logic                notify_hit_o
);

  stfo_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      entry_q <= ctrl_i.key;
    end else if (shift_en_i) begin
      entry_q <= next_entry_i;
    end
  end

  assign entry_o  = entry_q;
  assign key_eq_o = (entry_q == ctrl_i.key);

  // Wildcard group matches any key; otherwise group and id (or id wildcard).
  assign notify_hit_o = (entry_q.group == ctrl_i.group_wc) ||
                        ((entry_q.group == ctrl_i.key.group) &&
                         ((entry_q.id == ctrl_i.key.id) || (entry_q.id == ctrl_i.id_wc)));

endmodule

@@ src/stfo_pick.sv @@
// Highest-index set bit finder, used to select the newest matching slot.
`timescale 1ns / 1ps

module stfo_pick #(
  parameter int unsigned Width = 16,
  localparam int unsigned IdxW = (Width > 1) ? $clog2(Width) : 1
) (
  input  logic [Width-1:0] req_i,
  output logic             found_o,
  output logic [IdxW-1:0]  idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = 0; i < Width; i++) begin
      if (req_i[i]) begin
        found_o = 1'b1;
        idx_o   = IdxW'(i);
      end
    end
  end

endmodule

@@ src/subscription_table_fanout_core.sv @@
// Top level of the subscription table: cell chain, sequencer, result register and APB registers.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// --------  ---------------------  ------------------------------------------------
// input     in_valid_i/in_ready_o  func_i key_group_i key_id_i peer_ip_i peer_port_i
// output    out_valid_o/out_ready_i status_o match_valid_o match_ip_o match_port_o last_o
// config    psel/penable/pwrite    paddr pwdata, prdata read back, pready tied high
//
// One item at a time. Clear and refused requests go straight to the response state;
// unsubscribe steps through unsub and response, subscribe through evict, insert and
// response, notify through scan and then one result per emit step (one empty result
// when nothing matches, at most 16). The sequencer steps the cell chain: eviction
// shift, duplicate check with insert, and one result per cycle read out of the chain
// while the output register is free; output stalls hold the sequencer only while a
// result waits in the output register. The next input transfer is taken as soon as
// the sequencer is back in idle. Reset (rst_ni low, asynchronous) empties the table
// and restores register defaults; slot contents are not cleared, the fill count masks them.

module subscription_table_fanout_core #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  key_group_i,
  input  logic [7:0]  key_id_i,
  input  logic [31:0] peer_ip_i,
  input  logic [15:0] peer_port_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic        match_valid_o,
  output logic [31:0] match_ip_o,
  output logic [15:0] match_port_o,
  output logic        last_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_INSERT,
    ST_UNSUB,
    ST_SCAN,
    ST_EMIT,
    ST_RESP
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [4:0] max_subs_q;
  logic       safe_mode_q;
  logic [7:0] group_wc_q;
  logic [7:0] id_wc_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_subs_q  <= 5'd16;
      safe_mode_q <= 1'b0;
      group_wc_q  <= 8'hFF;
      id_wc_q     <= 8'hFF;
    end else if (psel && penable && pwrite) begin
      case (stfo_pkg::reg_e'(paddr[3:2]))
        stfo_pkg::REG_MAX_SUBS:  max_subs_q  <= pwdata[4:0];
        stfo_pkg::REG_SAFE_MODE: safe_mode_q <= pwdata[0];
        stfo_pkg::REG_GROUP_WC:  group_wc_q  <= pwdata[7:0];
        stfo_pkg::REG_ID_WC:     id_wc_q     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (stfo_pkg::reg_e'(paddr[3:2]))
      stfo_pkg::REG_MAX_SUBS:  prdata = 32'(max_subs_q);
      stfo_pkg::REG_SAFE_MODE: prdata = 32'(safe_mode_q);
      stfo_pkg::REG_GROUP_WC:  prdata = 32'(group_wc_q);
      stfo_pkg::REG_ID_WC:     prdata = 32'(id_wc_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_e                             state_q;
  stfo_pkg::entry_t                   key_q;
  logic                               resp_status_q;
  logic [CntW-1:0]                    count_q;
  logic [TABLE_DEPTH-1:0]             pend_q;
  logic [stfo_pkg::EmitCntW-1:0]      emit_cnt_q;

  logic                               out_valid_q;
  logic                               status_q;
  logic                               match_valid_q;
  logic [31:0]                        match_ip_q;
  logic [15:0]                        match_port_q;
  logic                               last_q;

  // ---------------------------------------------------------------------------
  // Cell chain: slot 0 is the oldest entry, slot count_q-1 the newest.
  // ---------------------------------------------------------------------------
  stfo_pkg::cell_ctrl_t   cell_ctrl;
  stfo_pkg::entry_t       entry_w [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] key_eq_w;
  logic [TABLE_DEPTH-1:0] hit_w;
  logic [TABLE_DEPTH-1:0] occ_w;
  logic [TABLE_DEPTH-1:0] shift_en_w;
  logic [TABLE_DEPTH-1:0] load_en_w;

  logic            uns_found;
  logic [IdxW-1:0] uns_idx;
  logic            top_found;
  logic [IdxW-1:0] top_idx;

  logic       dup;
  logic       evict_cond;
  logic       shift_all;
  logic       unsub_do;
  logic       insert_do;
  logic       out_free;
  logic       out_load;
  logic [7:0] lim_raw;
  logic [7:0] lim_eff;
  logic [TABLE_DEPTH-1:0] pend_rest;
  logic       emit_last;

  assign cell_ctrl.key      = key_q;
  assign cell_ctrl.group_wc = group_wc_q;
  assign cell_ctrl.id_wc    = id_wc_q;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    stfo_pkg::entry_t next_entry;

    // Top slot has no upper neighbor; it falls outside the fill after any shift.
    if (g == TABLE_DEPTH - 1) begin : g_top
      assign next_entry = entry_w[g];
    end else begin : g_mid
      assign next_entry = entry_w[g+1];
    end

    assign occ_w[g]      = (CntW'(g) < count_q);
    assign shift_en_w[g] = shift_all || (unsub_do && (IdxW'(g) >= uns_idx));
    assign load_en_w[g]  = insert_do && (count_q == CntW'(g));

    stfo_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .shift_en_i   (shift_en_w[g]),
      .load_en_i    (load_en_w[g]),
      .next_entry_i (next_entry),
      .entry_o      (entry_w[g]),
      .key_eq_o     (key_eq_w[g]),
      .notify_hit_o (hit_w[g])
    );
  end

  stfo_pick #(.Width(TABLE_DEPTH)) u_pick_unsub (
    .req_i   (key_eq_w & occ_w),
    .found_o (uns_found),
    .idx_o   (uns_idx)
  );

  stfo_pick #(.Width(TABLE_DEPTH)) u_pick_emit (
    .req_i   (pend_q),
    .found_o (top_found),
    .idx_o   (top_idx)
  );

  // Effective limit is the configured one capped at the table depth.
  assign lim_raw    = 8'(max_subs_q);
  assign lim_eff    = (lim_raw > 8'(TABLE_DEPTH)) ? 8'(TABLE_DEPTH) : lim_raw;
  assign evict_cond = (8'(count_q) >= lim_eff) && (count_q != '0);

  assign dup       = |(key_eq_w & occ_w);
  assign shift_all = (state_q == ST_EVICT) && evict_cond;
  assign unsub_do  = (state_q == ST_UNSUB) && uns_found;
  assign insert_do = (state_q == ST_INSERT) && !dup && (count_q < CntW'(TABLE_DEPTH));
  assign out_free  = !out_valid_q || out_ready_i;
  // A new result enters the output register this cycle.
  assign out_load  = ((state_q == ST_EMIT) || (state_q == ST_RESP)) && out_free;

  always_comb begin
    pend_rest          = pend_q;
    pend_rest[top_idx] = 1'b0;
  end

  // Final result: no other match left to report, or the result cap is reached.
  assign emit_last = (pend_rest == '0) ||
                     (emit_cnt_q == stfo_pkg::EmitCntW'(stfo_pkg::MaxResults - 1));

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      key_q         <= '0;
      resp_status_q <= 1'b0;
      count_q       <= '0;
      pend_q        <= '0;
      emit_cnt_q    <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= 1'b0;
      match_valid_q <= 1'b0;
      match_ip_q    <= '0;
      match_port_q  <= '0;
      last_q        <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            key_q         <= '{group: key_group_i, id: key_id_i,
                               ip: peer_ip_i, port: peer_port_i};
            resp_status_q <= 1'b0;
            case (stfo_pkg::func_e'(func_i))
              stfo_pkg::FUNC_SUBSCRIBE: begin
                if (safe_mode_q) begin
                  resp_status_q <= 1'b1;
                  state_q       <= ST_RESP;
                end else begin
                  state_q <= ST_EVICT;
                end
              end
              stfo_pkg::FUNC_UNSUBSCRIBE: state_q <= ST_UNSUB;
              stfo_pkg::FUNC_NOTIFY: begin
                if (safe_mode_q) begin
                  resp_status_q <= 1'b1;
                  state_q       <= ST_RESP;
                end else begin
                  state_q <= ST_SCAN;
                end
              end
              stfo_pkg::FUNC_CLEAR: begin
                count_q <= '0;
                state_q <= ST_RESP;
              end
              default: state_q <= ST_RESP;
            endcase
          end
        end

        ST_EVICT: begin
          // At the limit, drop the oldest entry; the whole chain moves down one slot.
          if (evict_cond) begin
            count_q <= count_q - CntW'(1);
          end
          state_q <= ST_INSERT;
        end

        ST_INSERT: begin
          if (insert_do) begin
            count_q <= count_q + CntW'(1);
          end
          state_q <= ST_RESP;
        end

        ST_UNSUB: begin
          if (unsub_do) begin
            count_q <= count_q - CntW'(1);
          end
          state_q <= ST_RESP;
        end

        ST_SCAN: begin
          pend_q     <= hit_w & occ_w;
          emit_cnt_q <= '0;
          state_q    <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= 1'b0;
            if (top_found) begin
              match_valid_q <= 1'b1;
              match_ip_q    <= entry_w[top_idx].ip;
              match_port_q  <= entry_w[top_idx].port;
              last_q        <= emit_last;
              pend_q        <= pend_rest;
              emit_cnt_q    <= emit_cnt_q + stfo_pkg::EmitCntW'(1);
              if (emit_last) begin
                state_q <= ST_IDLE;
              end
            end else begin
              // No subscriber matched: report one empty result.
              match_valid_q <= 1'b0;
              match_ip_q    <= '0;
              match_port_q  <= '0;
              last_q        <= 1'b1;
              state_q       <= ST_IDLE;
            end
          end
        end

        ST_RESP: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            status_q      <= resp_status_q;
            match_valid_q <= 1'b0;
            match_ip_q    <= '0;
            match_port_q  <= '0;
            last_q        <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign match_valid_o = match_valid_q;
  assign match_ip_o    = match_ip_q;
  assign match_port_o  = match_port_q;
  assign last_o        = last_q;

endmodule

@@ src/stfo_checker.sv @@
// Port-level assertions for the subscription table, bound to the top level.
`timescale 1ns / 1ps

module stfo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        status_o,
  input logic        match_valid_o,
  input logic [31:0] match_ip_o,
  input logic [15:0] match_port_o,
  input logic        last_o
);

  // Hold a stalled result until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A result without a subscriber always closes its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !match_valid_o |-> last_o)
    else $error("empty result not marked last");

  // Matched subscribers are never reported with a refusal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_valid_o |-> !status_o)
    else $error("match reported with refused status");

  // Empty results carry zero subscriber fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !match_valid_o |-> (match_ip_o == '0) && (match_port_o == '0))
    else $error("empty result carries a subscriber");

  // One item at a time: the block is busy right after an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous item in work");

endmodule

bind subscription_table_fanout_core stfo_checker u_stfo_checker (.*);
